FILE: src/pst_pkg.sv
package pst_pkg;

    localparam int OP_W  = 3;
    localparam int POS_W = 8;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int RD_W  = 32;

    localparam int IN_W  = ((OP_W + POS_W + VAL_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_END = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_END   = 3'd5;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_store_ctrl;

endpackage

FILE: src/pst_store.sv
module pst_store #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 4
) (
    input  logic                    i_clk,
    input  pst_pkg::t_store_ctrl    i_ctrl,
    input  logic [IDX_W-1:0]        i_idx,
    input  logic [DATA_WIDTH-1:0]   i_wr_data,
    output logic [DATA_WIDTH-1:0]   o_rd_data
);
    import pst_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
        localparam logic [IDX_W-1:0] GI = IDX_W'(g);
        always_ff @(posedge i_clk) begin
            if (i_ctrl.ins) begin
                if (GI == i_idx) begin
                    r_mem[g] <= i_wr_data;
                end
                if (g > 0) begin
                    if (GI > i_idx) begin
                        r_mem[g] <= r_mem[(g > 0) ? g - 1 : 0];
                    end
                end
            end else if (i_ctrl.rem) begin
                if (g < CAPACITY - 1) begin
                    if (GI >= i_idx) begin
                        r_mem[g] <= r_mem[(g < CAPACITY - 1) ? g + 1 : g];
                    end
                end
            end
        end
    end

    assign o_rd_data = r_mem[i_idx];

endmodule

FILE: src/positional_sequence_table.sv
// a registered result beat appears in the cycle after its input beat is accepted
// one beat per cycle unless output stalls; inserts/removals shift in parallel
// an input beat is taken whenever the result register is empty or being drained
// reset (synchronous, active low) clears the entry count and the result valid
// entry contents stay undefined until written; slots past the count are never read
module positional_sequence_table #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int OUT_W     = ((pst_pkg::ST_W + pst_pkg::RD_W + CNT_W + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // operation, position, value
    input  logic [pst_pkg::IN_W-1:0] i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // status, read_data, entry_count
    output logic [OUT_W-1:0]         o_m_axis_tdata
);
    import pst_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [OP_W-1:0]       in_op;
    logic [POS_W-1:0]      in_pos;
    logic [VAL_W-1:0]      in_value;
    logic                  accept;
    logic [CMP_W-1:0]      cnt_c;
    logic [CMP_W-1:0]      pos_c;
    logic [CMP_W-1:0]      last_c;
    logic [CMP_W-1:0]      cap_c;
    logic                  pos_past;
    logic [63:0]           val_ext;
    logic [63:0]           rd_ext;
    t_store_ctrl           op_ctrl;
    t_store_ctrl           st_ctrl;
    logic [IDX_W-1:0]      idx;
    logic [DATA_WIDTH-1:0] store_rd;
    logic                  rd_sel;
    logic [ST_W-1:0]       n_status;
    logic [CNT_W-1:0]      n_count;

    logic [CNT_W-1:0]      r_count;
    logic                  r_out_valid;
    logic [ST_W-1:0]       r_status;
    logic [RD_W-1:0]       r_rd;
    logic [CNT_W-1:0]      r_out_cnt;

    assign in_op    = i_s_axis_tdata[OP_W-1:0];
    assign in_pos   = i_s_axis_tdata[OP_W+POS_W-1:OP_W];
    assign in_value = i_s_axis_tdata[OP_W+POS_W+VAL_W-1:OP_W+POS_W];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign cnt_c    = CMP_W'(r_count);
    assign pos_c    = CMP_W'(in_pos);
    assign cap_c    = CMP_W'(CAPACITY);
    assign last_c   = cnt_c - CMP_W'(1);
    assign pos_past = pos_c >= cnt_c;
    assign val_ext  = 64'(in_value);
    assign rd_ext   = 64'(store_rd);

    always_comb begin
        op_ctrl  = '0;
        idx      = pos_c[IDX_W-1:0];
        rd_sel   = 1'b0;
        n_status = ST_OK;
        n_count  = r_count;
        case (in_op)
            OP_APPEND, OP_INSERT: begin
                if (cnt_c == cap_c) begin
                    n_status = ST_FULL;
                end else begin
                    op_ctrl.ins = 1'b1;
                    n_count     = r_count + CNT_W'(1);
                    if (in_op == OP_APPEND || pos_past) begin
                        idx = cnt_c[IDX_W-1:0];
                    end
                end
            end
            OP_REMOVE_END, OP_REMOVE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    op_ctrl.rem = 1'b1;
                    n_count     = r_count - CNT_W'(1);
                    if (in_op == OP_REMOVE_END || pos_past) begin
                        idx = last_c[IDX_W-1:0];
                    end
                end
            end
            OP_READ: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (pos_past) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    rd_sel = 1'b1;
                end
            end
            OP_READ_END: begin
                idx = last_c[IDX_W-1:0];
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_sel = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign st_ctrl.ins = op_ctrl.ins && accept;
    assign st_ctrl.rem = op_ctrl.rem && accept;

    pst_store #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctrl    (st_ctrl),
        .i_idx     (idx),
        .i_wr_data (val_ext[DATA_WIDTH-1:0]),
        .o_rd_data (store_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_rd      <= rd_sel ? rd_ext[RD_W-1:0] : '0;
            r_out_cnt <= n_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_cnt, r_rd, r_status});

endmodule
